// ===== rtl/usbreq_pkg.sv =====
// ----------------------------------------------------------------------------
// usbreq_pkg
// Shared types, codes and helpers for the USB standard request handler.
// ----------------------------------------------------------------------------
package usbreq_pkg;

  // bmRequestType type field (bits 6:5)
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;

  // Standard request codes
  localparam logic [7:0] STD_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] STD_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] STD_GET_CONFIG     = 8'h08;
  localparam logic [7:0] STD_SET_CONFIG     = 8'h09;

  // CDC line requests
  localparam logic [7:0] REQ_SET_LINE_CODING        = 8'h20;
  localparam logic [7:0] REQ_GET_LINE_CODING        = 8'h21;
  localparam logic [7:0] REQ_SET_CONTROL_LINE_STATE = 8'h22;

  // Descriptor types (wValue high byte)
  localparam logic [7:0] DT_DEVICE     = 8'h01;
  localparam logic [7:0] DT_CONFIG     = 8'h02;
  localparam logic [7:0] DT_STRING     = 8'h03;
  localparam logic [7:0] DT_HID_REPORT = 8'h22;

  // String indexes
  localparam logic [7:0] STR_LANGID       = 8'd0;
  localparam logic [7:0] STR_MANUFACTURER = 8'd1;
  localparam logic [7:0] STR_PRODUCT      = 8'd2;

  // Device states
  localparam logic [1:0] ST_DEFAULT    = 2'd0;
  localparam logic [1:0] ST_ADDRESSED  = 2'd1;
  localparam logic [1:0] ST_CONFIGURED = 2'd2;

  // Endpoint-zero phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_STATUS_IN = 3'd1;
  localparam logic [2:0] PH_DATA_IN   = 3'd2;
  localparam logic [2:0] PH_DATA_OUT  = 3'd3;
  localparam logic [2:0] PH_STALL     = 3'd4;

  // Response kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_ZLP   = 2'd1;
  localparam logic [1:0] RK_DATA  = 2'd2;
  localparam logic [1:0] RK_STALL = 2'd3;

  // Data sources
  localparam logic [2:0] SRC_DEVICE       = 3'd0;
  localparam logic [2:0] SRC_CONFIG       = 3'd1;
  localparam logic [2:0] SRC_STRING0      = 3'd2;
  localparam logic [2:0] SRC_MANUFACTURER = 3'd3;
  localparam logic [2:0] SRC_PRODUCT      = 3'd4;
  localparam logic [2:0] SRC_HID_REPORT   = 3'd5;
  localparam logic [2:0] SRC_SINGLE_BYTE  = 3'd6;

  // Events
  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_ADDRESS    = 2'd1;
  localparam logic [1:0] EV_CONFIGURED = 2'd2;

  // Fixed descriptor lengths
  localparam logic [15:0] DEVICE_DESC_LEN = 16'd18;
  localparam logic [15:0] HID_REPORT_LEN  = 16'd76;

  // Configuration register indexes
  localparam logic [2:0] CFG_CONF_VALUE   = 3'd0;
  localparam logic [2:0] CFG_TOTAL_LENGTH = 3'd1;
  localparam logic [2:0] CFG_STR0_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_MANUF_LENGTH = 3'd3;
  localparam logic [2:0] CFG_PROD_LENGTH  = 3'd4;

  typedef struct packed {
    logic [7:0]  configuration_value;
    logic [15:0] config_total_length;
    logic [7:0]  string0_length;
    logic [7:0]  manufacturer_string_length;
    logic [7:0]  product_string_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    logic [1:0] state;
    logic [6:0] addr;
    logic [2:0] phase;
  } dev_t;

  typedef struct packed {
    logic [1:0]  response_kind;
    logic [2:0]  data_source;
    logic [7:0]  data_byte;
    logic [15:0] data_length;
    logic [2:0]  ep0_phase;
    logic [1:0]  device_state_out;
    logic [6:0]  device_address_out;
    logic        activate_endpoints;
    logic [1:0]  event_code;
    logic        class_request;
    logic        type_error;
  } res_t;

  // Smaller of a descriptor length and wLength
  function automatic logic [15:0] clip16(input logic [15:0] a, input logic [15:0] b);
    clip16 = (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/usbreq_cfg.sv =====
// ----------------------------------------------------------------------------
// usbreq_cfg
// APB register file holding the descriptor lengths and configuration value.
// ----------------------------------------------------------------------------
module usbreq_cfg
  import usbreq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.configuration_value        <= 8'd1;
      cfg.config_total_length        <= 16'd32;
      cfg.string0_length             <= 8'd4;
      cfg.manufacturer_string_length <= 8'd2;
      cfg.product_string_length      <= 8'd2;
    end else if (wr_en) begin
      case (reg_idx)
        CFG_CONF_VALUE:   cfg.configuration_value        <= pwdata[7:0];
        CFG_TOTAL_LENGTH: cfg.config_total_length        <= pwdata[15:0];
        CFG_STR0_LENGTH:  cfg.string0_length             <= pwdata[7:0];
        CFG_MANUF_LENGTH: cfg.manufacturer_string_length <= pwdata[7:0];
        CFG_PROD_LENGTH:  cfg.product_string_length      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      CFG_CONF_VALUE:   prdata = {24'd0, cfg.configuration_value};
      CFG_TOTAL_LENGTH: prdata = {16'd0, cfg.config_total_length};
      CFG_STR0_LENGTH:  prdata = {24'd0, cfg.string0_length};
      CFG_MANUF_LENGTH: prdata = {24'd0, cfg.manufacturer_string_length};
      CFG_PROD_LENGTH:  prdata = {24'd0, cfg.product_string_length};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/usbreq_decode.sv =====
// ----------------------------------------------------------------------------
// usbreq_decode
// Single-pass decode of one setup packet against the current device state.
// ----------------------------------------------------------------------------
module usbreq_decode
  import usbreq_pkg::*;
(
  input  req_t req,
  input  cfg_t cfg,
  input  dev_t cur,
  output dev_t nxt,
  output res_t res
);

  logic [1:0]  rtype;
  logic [7:0]  lo;
  logic [7:0]  dtype;
  logic [15:0] wlen;

  assign rtype = req.request_type[6:5];
  assign lo    = req.request_value[7:0];
  assign dtype = req.request_value[15:8];
  assign wlen  = req.request_length;

  always_comb begin
    nxt = cur;
    res = '0;

    if (rtype == RT_STANDARD) begin
      case (req.request_code)
        // Address latch, from any state
        STD_SET_ADDRESS: begin
          nxt.phase         = PH_STATUS_IN;
          nxt.addr          = req.request_value[6:0];
          nxt.state         = ST_ADDRESSED;
          res.event_code    = EV_ADDRESS;
          res.response_kind = RK_ZLP;
        end
        STD_SET_CONFIG: begin
          nxt.phase = PH_STATUS_IN;
          if (cur.state == ST_ADDRESSED) begin
            if (lo == cfg.configuration_value) begin
              nxt.state              = ST_CONFIGURED;
              res.event_code         = EV_CONFIGURED;
              res.activate_endpoints = 1'b1;
              res.response_kind      = RK_ZLP;
            end else if (lo != 8'd0) begin
              res.response_kind = RK_STALL;
              nxt.phase         = PH_STALL;
            end else begin
              res.response_kind = RK_ZLP;
            end
          end else if (cur.state == ST_CONFIGURED) begin
            if (lo == 8'd0) begin
              nxt.state         = ST_ADDRESSED;
              res.response_kind = RK_ZLP;
            end else if (lo != cfg.configuration_value) begin
              res.response_kind = RK_STALL;
              nxt.phase         = PH_STALL;
            end else begin
              res.response_kind = RK_ZLP;
            end
          end
        end
        STD_GET_CONFIG: begin
          nxt.phase = PH_DATA_IN;
          if (cur.state == ST_CONFIGURED || cur.state == ST_ADDRESSED) begin
            res.response_kind = RK_DATA;
            res.data_source   = SRC_SINGLE_BYTE;
            res.data_byte     = (cur.state == ST_CONFIGURED) ?
                                cfg.configuration_value : 8'd0;
            res.data_length   = clip16(16'd1, wlen);
          end else begin
            res.response_kind = RK_STALL;
            nxt.phase         = PH_STALL;
          end
        end
        STD_GET_DESCRIPTOR: begin
          nxt.phase = PH_DATA_IN;
          if (dtype == DT_DEVICE) begin
            res.response_kind = RK_DATA;
            res.data_source   = SRC_DEVICE;
            res.data_length   = clip16(DEVICE_DESC_LEN, wlen);
          end else if (dtype == DT_CONFIG) begin
            res.response_kind = RK_DATA;
            res.data_source   = SRC_CONFIG;
            res.data_length   = clip16(cfg.config_total_length, wlen);
          end else if (dtype == DT_STRING) begin
            if (lo == STR_LANGID) begin
              res.response_kind = RK_DATA;
              res.data_source   = SRC_STRING0;
              res.data_length   = clip16({8'd0, cfg.string0_length}, wlen);
            end else if (lo == STR_MANUFACTURER) begin
              res.response_kind = RK_DATA;
              res.data_source   = SRC_MANUFACTURER;
              res.data_length   = clip16({8'd0, cfg.manufacturer_string_length}, wlen);
            end else if (lo == STR_PRODUCT) begin
              res.response_kind = RK_DATA;
              res.data_source   = SRC_PRODUCT;
              res.data_length   = clip16({8'd0, cfg.product_string_length}, wlen);
            end else begin
              res.response_kind = RK_ZLP;
            end
          end else if (dtype == DT_HID_REPORT) begin
            // report descriptor length is fixed, not clipped
            res.response_kind = RK_DATA;
            res.data_source   = SRC_HID_REPORT;
            res.data_length   = HID_REPORT_LEN;
          end
        end
        default: ;
      endcase
    end else if (rtype == RT_CLASS) begin
      // CDC line requests: flag and set phase, class logic answers
      case (req.request_code)
        REQ_SET_LINE_CODING: begin
          res.class_request = 1'b1;
          nxt.phase         = PH_DATA_OUT;
        end
        REQ_GET_LINE_CODING: begin
          res.class_request = 1'b1;
          nxt.phase         = PH_DATA_IN;
        end
        REQ_SET_CONTROL_LINE_STATE: begin
          res.class_request = 1'b1;
          nxt.phase         = PH_STATUS_IN;
        end
        default: ;
      endcase
    end else begin
      res.type_error = 1'b1;
    end

    res.ep0_phase          = nxt.phase;
    res.device_state_out   = nxt.state;
    res.device_address_out = nxt.addr;
  end

endmodule

// ===== rtl/usb_standard_request_handler.sv =====
// ----------------------------------------------------------------------------
// usb_standard_request_handler
// Endpoint-zero chapter 9 decoder: one setup packet in, one response out.
//
//   Channel  | Handshake          | Beat contents
//   ---------+--------------------+-------------------------------------------
//   in       | in_valid/in_stall  | request_type/code/value/length
//   out      | out_valid/out_stall| response, data, phase, device state, flags
//   config   | APB                | configuration value, descriptor lengths
//
// Two register stages: input register, then result register. One beat per
// cycle sustained while out_stall is low; the decode between the stages is
// shallow logic. Device state, address and phase update as a beat enters the
// result register. A stalled result holds; the input register takes a beat
// while it is empty itself or the result register is empty or draining.
// Synchronous reset clears the valid flags and the device state.
// ----------------------------------------------------------------------------
module usb_standard_request_handler
  import usbreq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_length,
  // response channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  response_kind,
  output logic [2:0]  data_source,
  output logic [7:0]  data_byte,
  output logic [15:0] data_length,
  output logic [2:0]  ep0_phase,
  output logic [1:0]  device_state_out,
  output logic [6:0]  device_address_out,
  output logic        activate_endpoints,
  output logic [1:0]  event_code,
  output logic        class_request,
  output logic        type_error,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  req_t s1_req;
  logic s1_valid;
  dev_t dev;
  dev_t dev_next;
  res_t dec_res;
  res_t res;
  logic out_load;
  logic in_accept;

  usbreq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake
  assign out_load  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_req <= '{request_type, request_code, request_value, request_length};
    end
  end

  usbreq_decode u_decode (
    .req (s1_req),
    .cfg (cfg),
    .cur (dev),
    .nxt (dev_next),
    .res (dec_res)
  );

  // Result register and device state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dev       <= '{ST_DEFAULT, 7'd0, PH_IDLE};
    end else if (out_load) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        dev <= dev_next;
      end
    end
    if (out_load && s1_valid) begin
      res <= dec_res;
    end
  end

  assign response_kind      = res.response_kind;
  assign data_source        = res.data_source;
  assign data_byte          = res.data_byte;
  assign data_length        = res.data_length;
  assign ep0_phase          = res.ep0_phase;
  assign device_state_out   = res.device_state_out;
  assign device_address_out = res.device_address_out;
  assign activate_endpoints = res.activate_endpoints;
  assign event_code         = res.event_code;
  assign class_request      = res.class_request;
  assign type_error         = res.type_error;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_stall |=> out_valid)
    else $error("held request did not reach result register");

  a_activate_cfg: assert property (@(posedge clk) disable iff (rst)
    out_valid && activate_endpoints |->
      device_state_out == ST_CONFIGURED && event_code == EV_CONFIGURED)
    else $error("endpoint activation without configuration");

  a_terr_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && type_error |-> response_kind == RK_NONE && !class_request)
    else $error("type error produced a response");

  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && response_kind != RK_DATA |->
      data_length == 16'd0 && data_source == SRC_DEVICE && data_byte == 8'd0)
    else $error("data fields set without data response");

  a_state_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> device_state_out == dev.state && device_address_out == dev.addr)
    else $error("reported state differs from stored state");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the endpoint-zero standard request decoder. Setup
// packets are queued by a stimulus process and presented by a clocked driver.
// Each accepted beat runs through a shadow decoder that tracks device state,
// address, phase and register values, and the expected response is queued. A
// clocked monitor compares every response beat field by field. A directed
// sweep runs first. Random phases follow, each under its own register set
// and its own sender-idle and receiver-stall mix.
// ----------------------------------------------------------------------------
module tb_top;
  import usbreq_pkg::*;

  // bmRequestType values used by the stimulus (direction, type, recipient)
  localparam logic [1:0] RT_VENDOR    = 2'd2;
  localparam logic [1:0] RT_RESERVED  = 2'd3;
  localparam logic [7:0] BM_STD_OUT   = {1'b0, RT_STANDARD, 5'd0};
  localparam logic [7:0] BM_STD_IN    = {1'b1, RT_STANDARD, 5'd0};
  localparam logic [7:0] BM_CLASS_OUT = {1'b0, RT_CLASS, 5'd1};
  localparam logic [7:0] BM_CLASS_IN  = {1'b1, RT_CLASS, 5'd1};
  localparam logic [7:0] BM_VENDOR    = {1'b0, RT_VENDOR, 5'd0};
  localparam logic [7:0] BM_RESERVED  = {1'b1, RT_RESERVED, 5'h1f};
  localparam int         DRAIN_LIMIT  = 50000;
  localparam int         PRINT_LIMIT  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  request_type = '0;
  logic [7:0]  request_code = '0;
  logic [15:0] request_value = '0;
  logic [15:0] request_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  response_kind;
  logic [2:0]  data_source;
  logic [7:0]  data_byte;
  logic [15:0] data_length;
  logic [2:0]  ep0_phase;
  logic [1:0]  device_state_out;
  logic [6:0]  device_address_out;
  logic        activate_endpoints;
  logic [1:0]  event_code;
  logic        class_request;
  logic        type_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the decoder state and registers
  logic [1:0]  shadow_state;
  logic [6:0]  shadow_addr;
  logic [2:0]  shadow_phase;
  cfg_t        shadow_regs;

  req_t        setup_backlog[$];
  res_t        awaited_responses[$];
  req_t        presented;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic        hold_sender = 1'b0;
  int          failure_count = 0;
  int          responses_seen = 0;

  usb_standard_request_handler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .request_type(request_type), .request_code(request_code),
    .request_value(request_value), .request_length(request_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .response_kind(response_kind), .data_source(data_source),
    .data_byte(data_byte), .data_length(data_length),
    .ep0_phase(ep0_phase), .device_state_out(device_state_out),
    .device_address_out(device_address_out),
    .activate_endpoints(activate_endpoints), .event_code(event_code),
    .class_request(class_request), .type_error(type_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_failure(input string msg);
    failure_count++;
    if (failure_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // descriptor data stage, clipped to wLength
  function automatic void load_data_reply(inout res_t r, input logic [2:0] src,
                                          input logic [15:0] full_len,
                                          input logic [15:0] wlen);
    r.response_kind = RK_DATA;
    r.data_source   = src;
    r.data_length   = (full_len < wlen) ? full_len : wlen;
  endfunction

  // Decode one setup packet against the shadow state; updates the shadow.
  function automatic res_t decode_setup_packet(input req_t pkt);
    res_t       r;
    logic [7:0] low_byte;
    logic [7:0] desc_type;
    r = '0;
    low_byte  = pkt.request_value[7:0];
    desc_type = pkt.request_value[15:8];
    case (pkt.request_type[6:5])
      RT_STANDARD: begin
        case (pkt.request_code)
          STD_SET_ADDRESS: begin
            shadow_phase    = PH_STATUS_IN;
            shadow_addr     = pkt.request_value[6:0];
            shadow_state    = ST_ADDRESSED;
            r.event_code    = EV_ADDRESS;
            r.response_kind = RK_ZLP;
          end
          STD_SET_CONFIG: begin
            shadow_phase = PH_STATUS_IN;
            if (shadow_state == ST_ADDRESSED) begin
              if (low_byte == shadow_regs.configuration_value) begin
                shadow_state         = ST_CONFIGURED;
                r.event_code         = EV_CONFIGURED;
                r.activate_endpoints = 1'b1;
                r.response_kind      = RK_ZLP;
              end else if (low_byte != 8'd0) begin
                r.response_kind = RK_STALL;
                shadow_phase    = PH_STALL;
              end else begin
                r.response_kind = RK_ZLP;
              end
            end else if (shadow_state == ST_CONFIGURED) begin
              if (low_byte == 8'd0) begin
                shadow_state    = ST_ADDRESSED;
                r.response_kind = RK_ZLP;
              end else if (low_byte != shadow_regs.configuration_value) begin
                r.response_kind = RK_STALL;
                shadow_phase    = PH_STALL;
              end else begin
                r.response_kind = RK_ZLP;
              end
            end
          end
          STD_GET_CONFIG: begin
            shadow_phase = PH_DATA_IN;
            if (shadow_state == ST_CONFIGURED || shadow_state == ST_ADDRESSED) begin
              load_data_reply(r, SRC_SINGLE_BYTE, 16'd1, pkt.request_length);
              r.data_byte = (shadow_state == ST_CONFIGURED) ?
                            shadow_regs.configuration_value : 8'd0;
            end else begin
              r.response_kind = RK_STALL;
              shadow_phase    = PH_STALL;
            end
          end
          STD_GET_DESCRIPTOR: begin
            shadow_phase = PH_DATA_IN;
            case (desc_type)
              DT_DEVICE: load_data_reply(r, SRC_DEVICE, DEVICE_DESC_LEN, pkt.request_length);
              DT_CONFIG: begin
                load_data_reply(r, SRC_CONFIG, shadow_regs.config_total_length,
                                pkt.request_length);
              end
              DT_STRING: begin
                case (low_byte)
                  STR_LANGID: begin
                    load_data_reply(r, SRC_STRING0, {8'd0, shadow_regs.string0_length},
                                    pkt.request_length);
                  end
                  STR_MANUFACTURER: begin
                    load_data_reply(r, SRC_MANUFACTURER,
                                    {8'd0, shadow_regs.manufacturer_string_length},
                                    pkt.request_length);
                  end
                  STR_PRODUCT: begin
                    load_data_reply(r, SRC_PRODUCT,
                                    {8'd0, shadow_regs.product_string_length},
                                    pkt.request_length);
                  end
                  default: r.response_kind = RK_ZLP;
                endcase
              end
              // report descriptor ignores wLength
              DT_HID_REPORT: begin
                r.response_kind = RK_DATA;
                r.data_source   = SRC_HID_REPORT;
                r.data_length   = HID_REPORT_LEN;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      RT_CLASS: begin
        case (pkt.request_code)
          REQ_SET_LINE_CODING: begin
            r.class_request = 1'b1;
            shadow_phase    = PH_DATA_OUT;
          end
          REQ_GET_LINE_CODING: begin
            r.class_request = 1'b1;
            shadow_phase    = PH_DATA_IN;
          end
          REQ_SET_CONTROL_LINE_STATE: begin
            r.class_request = 1'b1;
            shadow_phase    = PH_STATUS_IN;
          end
          default: ;
        endcase
      end
      default: r.type_error = 1'b1;
    endcase
    r.ep0_phase          = shadow_phase;
    r.device_state_out   = shadow_state;
    r.device_address_out = shadow_addr;
    return r;
  endfunction

  function automatic req_t random_packet();
    req_t p;
    int   pick;
    p.request_type   = 8'($urandom_range(255));
    p.request_code   = 8'($urandom_range(255));
    p.request_value  = 16'($urandom_range(65535));
    p.request_length = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 70) begin
      // well-formed standard request with random content
      p.request_type[6:5] = RT_STANDARD;
      case ($urandom_range(3))
        0: p.request_code = STD_SET_ADDRESS;
        1: begin
          p.request_code = STD_SET_CONFIG;
          case ($urandom_range(3))
            0: p.request_value[7:0] = 8'd0;
            1, 2: p.request_value[7:0] = shadow_regs.configuration_value;
            default: ;
          endcase
        end
        2: p.request_code = STD_GET_CONFIG;
        default: begin
          p.request_code = STD_GET_DESCRIPTOR;
          case ($urandom_range(5))
            0: p.request_value[15:8] = DT_DEVICE;
            1: p.request_value[15:8] = DT_CONFIG;
            2, 3: p.request_value[15:8] = DT_STRING;
            4: p.request_value[15:8] = DT_HID_REPORT;
            default: ;
          endcase
          case ($urandom_range(4))
            0: p.request_value[7:0] = STR_LANGID;
            1: p.request_value[7:0] = STR_MANUFACTURER;
            2: p.request_value[7:0] = STR_PRODUCT;
            default: ;
          endcase
        end
      endcase
    end else if (pick < 88) begin
      p.request_type[6:5] = RT_CLASS;
      case ($urandom_range(3))
        0: p.request_code = REQ_SET_LINE_CODING;
        1: p.request_code = REQ_GET_LINE_CODING;
        2: p.request_code = REQ_SET_CONTROL_LINE_STATE;
        default: ;
      endcase
    end else if (pick < 95) begin
      p.request_type[6:5] = ($urandom_range(1) == 0) ? RT_VENDOR : RT_RESERVED;
    end
    // remaining picks keep a fully random packet as noise
    case ($urandom_range(3))
      0: p.request_length = 16'd0;
      1: p.request_length = 16'($urandom_range(80));
      2: p.request_length = 16'hffff;
      default: ;
    endcase
    return p;
  endfunction

  task automatic queue_packet(input logic [7:0] rtype, input logic [7:0] code,
                              input logic [15:0] value, input logic [15:0] length);
    req_t p;
    p.request_type   = rtype;
    p.request_code   = code;
    p.request_value  = value;
    p.request_length = length;
    setup_backlog.push_back(p);
  endtask

  // APB write: setup then access; shadow follows at the access edge
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CFG_CONF_VALUE:   shadow_regs.configuration_value        = value[7:0];
      CFG_TOTAL_LENGTH: shadow_regs.config_total_length        = value[15:0];
      CFG_STR0_LENGTH:  shadow_regs.string0_length             = value[7:0];
      CFG_MANUF_LENGTH: shadow_regs.manufacturer_string_length = value[7:0];
      CFG_PROD_LENGTH:  shadow_regs.product_string_length      = value[7:0];
      default: ;
    endcase
  endtask

  task automatic program_registers(input int conf, input int total, input int str0,
                                   input int manuf, input int prod);
    write_register(CFG_CONF_VALUE, 32'(conf));
    write_register(CFG_TOTAL_LENGTH, 32'(total));
    write_register(CFG_STR0_LENGTH, 32'(str0));
    write_register(CFG_MANUF_LENGTH, 32'(manuf));
    write_register(CFG_PROD_LENGTH, 32'(prod));
  endtask

  // wait until no beat is in flight, then let the pipeline settle;
  // sampled mid-cycle so the driver's updates at the edge are settled
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    while (((!hold_sender && setup_backlog.size() != 0) || in_valid ||
            awaited_responses.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      report_failure($sformatf("%0d responses never arrived", awaited_responses.size()));
      awaited_responses.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                           input bit with_pause);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) setup_backlog.push_back(random_packet());
    if (with_pause) begin
      while (setup_backlog.size() > count / 2) @(posedge clk);
      // sender holds off until every outstanding response is back
      hold_sender = 1'b1;
      wait_drained();
      hold_sender = 1'b0;
    end
    wait_drained();
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_failure($sformatf("response %0d %s: got %0d expected %0d",
                               responses_seen, name, got, want));
    end
  endtask

  task automatic check_response();
    res_t want;
    if (awaited_responses.size() == 0) begin
      report_failure($sformatf("response %0d arrived with none outstanding", responses_seen));
    end else begin
      want = awaited_responses.pop_front();
      compare_field("response_kind", response_kind, want.response_kind);
      compare_field("data_source", data_source, want.data_source);
      compare_field("data_byte", data_byte, want.data_byte);
      compare_field("data_length", data_length, want.data_length);
      compare_field("ep0_phase", ep0_phase, want.ep0_phase);
      compare_field("device_state_out", device_state_out, want.device_state_out);
      compare_field("device_address_out", device_address_out, want.device_address_out);
      compare_field("activate_endpoints", activate_endpoints, want.activate_endpoints);
      compare_field("event_code", event_code, want.event_code);
      compare_field("class_request", class_request, want.class_request);
      compare_field("type_error", type_error, want.type_error);
    end
    responses_seen++;
  endtask

  // Request driver: predict on each accepted beat, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) awaited_responses.push_back(decode_setup_packet(presented));
      if (!in_valid || !in_stall) begin
        if (!hold_sender && setup_backlog.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          presented = setup_backlog.pop_front();
          request_type   <= presented.request_type;
          request_code   <= presented.request_code;
          request_value  <= presented.request_value;
          request_length <= presented.request_length;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_response();
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Stimulus sequence
  initial begin
    shadow_state = ST_DEFAULT;
    shadow_addr  = '0;
    shadow_phase = PH_IDLE;
    shadow_regs.configuration_value        = 8'd1;
    shadow_regs.config_total_length        = 16'd32;
    shadow_regs.string0_length             = 8'd4;
    shadow_regs.manufacturer_string_length = 8'd2;
    shadow_regs.product_string_length      = 8'd2;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sweep under reset register values
    queue_packet(BM_STD_IN, STD_GET_CONFIG, 16'h0000, 16'h0001);      // default: stall
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'h0001, 16'h0000);     // default: none
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'hffff);
    queue_packet(BM_STD_OUT, STD_SET_ADDRESS, 16'hffff, 16'hffff);    // low 7 bits only
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'h0000, 16'h0000);     // stay addressed
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'h0005, 16'h0000);     // unknown: stall
    queue_packet(BM_STD_IN, STD_GET_CONFIG, 16'h0000, 16'h0001);      // addressed: byte 0
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'hff01, 16'h0000);     // high byte ignored
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'h0001, 16'h0000);     // same config
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'h00fe, 16'h0000);     // unknown: stall
    queue_packet(BM_STD_IN, STD_GET_CONFIG, 16'h0000, 16'h0000);      // zero-length data
    queue_packet(BM_STD_IN, STD_GET_CONFIG, 16'hffff, 16'hffff);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'hffff);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0003);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, STR_LANGID}, 16'hffff);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, STR_MANUFACTURER}, 16'h0001);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, STR_PRODUCT}, 16'hffff);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_STRING, 8'hff}, 16'hffff);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, {DT_HID_REPORT, 8'h00}, 16'h0000);
    queue_packet(BM_STD_IN, STD_GET_DESCRIPTOR, 16'hff00, 16'hffff);  // unknown type
    queue_packet(BM_CLASS_OUT, REQ_SET_LINE_CODING, 16'h0000, 16'h0007);
    queue_packet(BM_CLASS_IN, REQ_GET_LINE_CODING, 16'h0000, 16'h0007);
    queue_packet(BM_CLASS_OUT, REQ_SET_CONTROL_LINE_STATE, 16'h0003, 16'h0000);
    queue_packet(BM_CLASS_OUT, 8'hff, 16'hffff, 16'hffff);            // other class code
    queue_packet(BM_STD_IN, 8'h00, 16'h0000, 16'h0002);               // other standard
    queue_packet(BM_VENDOR, STD_SET_ADDRESS, 16'h0011, 16'h0000);     // type error
    queue_packet(BM_RESERVED, STD_GET_DESCRIPTOR, 16'hffff, 16'hffff); // type error
    queue_packet(BM_STD_OUT, STD_SET_CONFIG, 16'h0000, 16'h0000);
    wait_drained();

    // random phases, each under its own register set and idling mix
    program_registers(1, 9, 2, 2, 2);
    run_phase(375, 0, 0, 1'b0);
    program_registers(255, 65535, 255, 255, 255);
    run_phase(375, 62, 0, 1'b1);
    program_registers($urandom_range(2, 254), $urandom_range(10, 200),
                      $urandom_range(3, 60), $urandom_range(3, 60), $urandom_range(3, 60));
    run_phase(375, 0, 62, 1'b0);
    program_registers($urandom_range(1, 255), $urandom_range(9, 65535),
                      $urandom_range(2, 255), $urandom_range(2, 255),
                      $urandom_range(2, 255));
    run_phase(375, 35, 35, 1'b0);

    if (failure_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/usbreq_pkg.sv
rtl/usbreq_cfg.sv
rtl/usbreq_decode.sv
rtl/usb_standard_request_handler.sv
tb/sv/tb_top.sv
